// ===== hdl/qmru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmru_pkg: shared definitions for the quaternion multiply / rotate unit
// Fixed-point widths, mode codes, pipeline latency and the round/saturate
// helper used by both product passes.
// ----------------------------------------------------------------------------
package qmru_pkg;

	localparam int DATA_W  = 16;
	localparam int FRAC_W  = 14;
	localparam int MODE_W  = 3;
	// one guard bit so a negated operand of the most negative value stays exact
	localparam int OP_W    = DATA_W + 1;
	localparam int PROD_W  = 2 * OP_W;
	// four products plus the rounding constant
	localparam int SUM_W   = PROD_W + 2;
	localparam int LATENCY = 7;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [MODE_W-1:0]        mode_t;

	localparam mode_t MODE_MUL     = mode_t'(0);
	localparam mode_t MODE_CONJ_A  = mode_t'(1);
	localparam mode_t MODE_CONJ_B  = mode_t'(2);
	localparam mode_t MODE_ROT     = mode_t'(3);
	localparam mode_t MODE_INV_ROT = mode_t'(4);

	localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);
	localparam sum_t SAT_MAX    = (sum_t'(1) <<< (DATA_W - 1)) - sum_t'(1);
	localparam sum_t SAT_MIN    = -SAT_MAX - sum_t'(1);

	typedef struct packed {
		data_t value;
		logic  ovf;
	} sat_t;

	function automatic prod_t mul(input op_t a, input op_t b);
		prod_t p;
		p = a * b;
		return p;
	endfunction

	function automatic sum_t ext(input prod_t p);
		return sum_t'(p);
	endfunction

	function automatic sum_t cneg(input sum_t s, input logic neg);
		return neg ? -s : s;
	endfunction

	// round half toward +inf, then clamp to the signed data range
	function automatic sat_t round_sat(input sum_t s);
		sum_t r;
		sat_t o;
		r = (s + ROUND_HALF) >>> FRAC_W;
		if (r > SAT_MAX) begin
			o.value = data_t'(SAT_MAX);
			o.ovf   = 1'b1;
		end else if (r < SAT_MIN) begin
			o.value = data_t'(SAT_MIN);
			o.ovf   = 1'b1;
		end else begin
			o.value = data_t'(r[DATA_W-1:0]);
			o.ovf   = 1'b0;
		end
		return o;
	endfunction

endpackage

// ===== hdl/quaternion_multiply_rotate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_unit: Hamilton product and vector rotation
// Fully pipelined Q2.14 quaternion multiply, conjugate multiply, rotate and
// inverse rotate, with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage: one item may be started on every clock; busy is never raised. Each
// result appears on res_* with done high, in start order and for every mode,
// once it has passed the two multiply passes (operand prep, products, sums,
// round/saturate, then second products, sums, round/saturate into the output
// register). done is a single cycle strobe; the receiver must take the beat in
// that cycle.
module quaternion_multiply_rotate_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qmru_pkg::mode_t   mode,
	input  qmru_pkg::data_t   qa_w,
	input  qmru_pkg::data_t   qa_x,
	input  qmru_pkg::data_t   qa_y,
	input  qmru_pkg::data_t   qa_z,
	input  qmru_pkg::data_t   qb_w,
	input  qmru_pkg::data_t   qb_x,
	input  qmru_pkg::data_t   qb_y,
	input  qmru_pkg::data_t   qb_z,
	output logic              done,
	output qmru_pkg::data_t   res_w,
	output qmru_pkg::data_t   res_x,
	output qmru_pkg::data_t   res_y,
	output qmru_pkg::data_t   res_z,
	output logic              overflow
);
	import qmru_pkg::*;

	// component index: 0 w, 1 x, 2 y, 3 z

	// stage 1: operand prep (conjugation folded into sign)
	logic  valid_s1;
	mode_t mode_s1;
	op_t   a_s1 [4];
	op_t   b_s1 [4];
	op_t   a_in [4];
	op_t   b_in [4];

	// stage 2: first-pass products a[i]*b[j]
	logic  valid_s2;
	mode_t mode_s2;
	op_t   a_s2 [4];
	prod_t p_s2 [4][4];

	// stage 3: first-pass sums
	logic  valid_s3;
	mode_t mode_s3;
	op_t   a_s3 [4];
	sum_t  sum_s3 [4];
	sum_t  sum_c [4];

	// stage 4: rounded first pass (quaternion result, or s1/x1/y1/z1)
	logic  valid_s4;
	mode_t mode_s4;
	op_t   a_s4 [4];
	data_t v_s4 [4];
	logic  ovf_s4;
	sat_t  sat1 [4];

	// stage 5: second-pass products
	logic  valid_s5;
	mode_t mode_s5;
	data_t v_s5 [4];
	logic  ovf_s5;
	prod_t ps_s5 [1:3];
	prod_t pw_s5 [1:3];
	prod_t pc_yz_s5, pc_zy_s5, pc_zx_s5, pc_xz_s5, pc_xy_s5, pc_yx_s5;

	// stage 6: second-pass sums
	logic  valid_s6;
	mode_t mode_s6;
	data_t v_s6 [4];
	logic  ovf_s6;
	sum_t  sum_s6 [1:3];
	sum_t  sum2_c [1:3];

	// stage 7: output register
	logic  valid_s7;
	data_t res_s7 [4];
	logic  ovf_s7;
	sat_t  sat2 [1:3];

	logic  inv_s2, inv_s5;
	logic  rot_s2, rot_s6, quat_s6;

	assign busy = 1'b0;

	always_comb begin
		a_in[0] = op_t'(qa_w);
		a_in[1] = op_t'(qa_x);
		a_in[2] = op_t'(qa_y);
		a_in[3] = op_t'(qa_z);
		b_in[0] = op_t'(qb_w);
		b_in[1] = op_t'(qb_x);
		b_in[2] = op_t'(qb_y);
		b_in[3] = op_t'(qb_z);
		if (mode == MODE_CONJ_A) begin
			for (int i = 1; i < 4; i++) a_in[i] = -a_in[i];
		end
		if (mode == MODE_CONJ_B) begin
			for (int i = 1; i < 4; i++) b_in[i] = -b_in[i];
		end
	end

	assign rot_s2 = (mode_s2 == MODE_ROT) || (mode_s2 == MODE_INV_ROT);
	assign inv_s2 = (mode_s2 == MODE_INV_ROT);

	always_comb begin
		sum_c[0] = '0;
		sum_c[1] = '0;
		sum_c[2] = '0;
		sum_c[3] = '0;
		if (rot_s2) begin
			// s1 and the first-stage vector x1/y1/z1; sign applied before rounding
			sum_c[0] = cneg(ext(p_s2[1][1]) + ext(p_s2[2][2]) + ext(p_s2[3][3]), inv_s2);
			sum_c[1] = ext(p_s2[0][1]) + cneg(ext(p_s2[2][3]) - ext(p_s2[3][2]), inv_s2);
			sum_c[2] = ext(p_s2[0][2]) + cneg(ext(p_s2[3][1]) - ext(p_s2[1][3]), inv_s2);
			sum_c[3] = ext(p_s2[0][3]) + cneg(ext(p_s2[1][2]) - ext(p_s2[2][1]), inv_s2);
		end else begin
			sum_c[0] = ext(p_s2[0][0]) - ext(p_s2[1][1]) - ext(p_s2[2][2])
				- ext(p_s2[3][3]);
			sum_c[1] = ext(p_s2[0][1]) + ext(p_s2[1][0]) + ext(p_s2[2][3])
				- ext(p_s2[3][2]);
			sum_c[2] = ext(p_s2[0][2]) + ext(p_s2[2][0]) + ext(p_s2[3][1])
				- ext(p_s2[1][3]);
			sum_c[3] = ext(p_s2[0][3]) + ext(p_s2[3][0]) + ext(p_s2[1][2])
				- ext(p_s2[2][1]);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) sat1[k] = round_sat(sum_s3[k]);
	end

	assign inv_s5 = (mode_s5 == MODE_INV_ROT);

	always_comb begin
		sum2_c[1] = cneg(ext(ps_s5[1]), inv_s5) + ext(pw_s5[1])
			+ cneg(ext(pc_yz_s5) - ext(pc_zy_s5), inv_s5);
		sum2_c[2] = cneg(ext(ps_s5[2]), inv_s5) + ext(pw_s5[2])
			+ cneg(ext(pc_zx_s5) - ext(pc_xz_s5), inv_s5);
		sum2_c[3] = cneg(ext(ps_s5[3]), inv_s5) + ext(pw_s5[3])
			+ cneg(ext(pc_xy_s5) - ext(pc_yx_s5), inv_s5);
	end

	assign rot_s6  = (mode_s6 == MODE_ROT) || (mode_s6 == MODE_INV_ROT);
	assign quat_s6 = (mode_s6 == MODE_MUL) || (mode_s6 == MODE_CONJ_A)
		|| (mode_s6 == MODE_CONJ_B);

	always_comb begin
		for (int k = 1; k < 4; k++) sat2[k] = round_sat(sum_s6[k]);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		a_s1    <= a_in;
		b_s1    <= b_in;

		mode_s2 <= mode_s1;
		a_s2    <= a_s1;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) p_s2[i][j] <= mul(a_s1[i], b_s1[j]);
		end

		mode_s3 <= mode_s2;
		a_s3    <= a_s2;
		sum_s3  <= sum_c;

		mode_s4 <= mode_s3;
		a_s4    <= a_s3;
		for (int k = 0; k < 4; k++) v_s4[k] <= sat1[k].value;
		ovf_s4  <= sat1[0].ovf | sat1[1].ovf | sat1[2].ovf | sat1[3].ovf;

		// in rotate modes v_s4 holds s1, x1, y1, z1
		mode_s5 <= mode_s4;
		v_s5    <= v_s4;
		ovf_s5  <= ovf_s4;
		for (int i = 1; i < 4; i++) begin
			ps_s5[i] <= mul(a_s4[i], op_t'(v_s4[0]));
			pw_s5[i] <= mul(a_s4[0], op_t'(v_s4[i]));
		end
		pc_yz_s5 <= mul(a_s4[2], op_t'(v_s4[3]));
		pc_zy_s5 <= mul(a_s4[3], op_t'(v_s4[2]));
		pc_zx_s5 <= mul(a_s4[3], op_t'(v_s4[1]));
		pc_xz_s5 <= mul(a_s4[1], op_t'(v_s4[3]));
		pc_xy_s5 <= mul(a_s4[1], op_t'(v_s4[2]));
		pc_yx_s5 <= mul(a_s4[2], op_t'(v_s4[1]));

		mode_s6 <= mode_s5;
		v_s6    <= v_s5;
		ovf_s6  <= ovf_s5;
		for (int k = 1; k < 4; k++) sum_s6[k] <= sum2_c[k];

		if (rot_s6) begin
			res_s7[0] <= '0;
			for (int k = 1; k < 4; k++) res_s7[k] <= sat2[k].value;
			ovf_s7 <= ovf_s6 | sat2[1].ovf | sat2[2].ovf | sat2[3].ovf;
		end else if (quat_s6) begin
			res_s7 <= v_s6;
			ovf_s7 <= ovf_s6;
		end else begin
			for (int k = 0; k < 4; k++) res_s7[k] <= '0;
			ovf_s7 <= 1'b0;
		end
	end

	assign done     = valid_s7;
	assign res_w    = res_s7[0];
	assign res_x    = res_s7[1];
	assign res_y    = res_s7[2];
	assign res_z    = res_s7[3];
	assign overflow = ovf_s7;

`ifndef SYNTH
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without a matching start beat");

	a_vec_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(mode, LATENCY) == MODE_ROT || $past(mode, LATENCY) == MODE_INV_ROT)
		|-> res_w == '0)
		else $error("vector mode result has nonzero scalar part");

	a_bad_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(mode, LATENCY) > MODE_INV_ROT
		|-> res_w == '0 && res_x == '0 && res_y == '0 && res_z == '0 && !overflow)
		else $error("unused mode code produced a nonzero result");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: quaternion multiply / rotate unit bench
// Streams directed corner cases and then about 900 random items through the
// unit with random start gaps, predicts each result in Q2.14 arithmetic with
// rounding and saturation, and checks every done beat in order.
// ----------------------------------------------------------------------------
module tb;
	import qmru_pkg::*;

	localparam mode_t  MODE_SPARE_FIRST = MODE_INV_ROT + mode_t'(1);
	localparam mode_t  MODE_SPARE_LAST  = '1;
	localparam data_t  Q_ONE   = data_t'(1 << FRAC_W);
	localparam data_t  Q_MAX   = data_t'((1 << (DATA_W - 1)) - 1);
	localparam data_t  Q_MIN   = data_t'(-(1 << (DATA_W - 1)));
	localparam data_t  Q_COS45 = data_t'(11585);
	localparam longint RND_HALF = longint'(1) << (FRAC_W - 1);
	localparam longint SAT_HI   = (longint'(1) << (DATA_W - 1)) - 1;
	localparam longint SAT_LO   = -SAT_HI - 1;
	localparam int     MAX_GAP  = 13;
	localparam int     N_RANDOM = 900;
	localparam int     PRINT_CAP = 40;

	typedef struct {
		mode_t op;
		data_t aw, ax, ay, az;
		data_t bw, bx, by, bz;
		int    gap;
		bit    drain;
	} quat_op_t;

	typedef struct {
		data_t w, x, y, z;
		logic  ovf;
	} quat_res_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	mode_t mode = '0;
	data_t qa_w = '0, qa_x = '0, qa_y = '0, qa_z = '0;
	data_t qb_w = '0, qb_x = '0, qb_y = '0, qb_z = '0;
	logic  busy, done, overflow;
	data_t res_w, res_x, res_y, res_z;

	quat_op_t  op_queue[$];
	quat_res_t res_queue[$];
	quat_op_t  next_op;
	bit        beat_taken = 1'b0;
	bit        gap_served = 1'b0;
	int        idle_left = 0;
	int        n_errors = 0;
	int        n_checked = 0;
	int        n_ovf = 0;
	int        mode_hits[8];

	quaternion_multiply_rotate_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.qa_w(qa_w), .qa_x(qa_x), .qa_y(qa_y), .qa_z(qa_z),
		.qb_w(qb_w), .qb_x(qb_x), .qb_y(qb_y), .qb_z(qb_z),
		.done(done), .res_w(res_w), .res_x(res_x), .res_y(res_y), .res_z(res_z),
		.overflow(overflow)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// exact sum in, round half up, clamp to the data range
	function automatic longint round_clamp(input longint s, inout bit ovf);
		longint r;
		r = (s + RND_HALF) >>> FRAC_W;
		if (r > SAT_HI) begin
			ovf = 1'b1;
			return SAT_HI;
		end
		if (r < SAT_LO) begin
			ovf = 1'b1;
			return SAT_LO;
		end
		return r;
	endfunction

	function automatic quat_res_t hamilton_or_rotate(input quat_op_t o);
		longint aw, ax, ay, az, bw, bx, by, bz, g, s1, x1, y1, z1;
		quat_res_t r;
		bit ovf;
		r = '{default: '0};
		ovf = 1'b0;
		aw = o.aw; ax = o.ax; ay = o.ay; az = o.az;
		bw = o.bw; bx = o.bx; by = o.by; bz = o.bz;
		case (o.op)
			MODE_MUL, MODE_CONJ_A, MODE_CONJ_B: begin
				if (o.op == MODE_CONJ_A) begin
					ax = -ax; ay = -ay; az = -az;
				end
				if (o.op == MODE_CONJ_B) begin
					bx = -bx; by = -by; bz = -bz;
				end
				r.w = data_t'(round_clamp(aw*bw - ax*bx - ay*by - az*bz, ovf));
				r.x = data_t'(round_clamp(aw*bx + ax*bw + ay*bz - az*by, ovf));
				r.y = data_t'(round_clamp(aw*by + ay*bw + az*bx - ax*bz, ovf));
				r.z = data_t'(round_clamp(aw*bz + az*bw + ax*by - ay*bx, ovf));
			end
			MODE_ROT, MODE_INV_ROT: begin
				g  = (o.op == MODE_ROT) ? 1 : -1;
				// first pass is rounded and clamped before the second product
				s1 = round_clamp(g * (ax*bx + ay*by + az*bz), ovf);
				x1 = round_clamp(aw*bx + g * (ay*bz - az*by), ovf);
				y1 = round_clamp(aw*by + g * (az*bx - ax*bz), ovf);
				z1 = round_clamp(aw*bz + g * (ax*by - ay*bx), ovf);
				r.x = data_t'(round_clamp(g*s1*ax + aw*x1 + g * (ay*z1 - az*y1), ovf));
				r.y = data_t'(round_clamp(g*s1*ay + aw*y1 + g * (az*x1 - ax*z1), ovf));
				r.z = data_t'(round_clamp(g*s1*az + aw*z1 + g * (ax*y1 - ay*x1), ovf));
			end
			default: ;
		endcase
		r.ovf = ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		if (n_errors <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic check_field(input string what, input longint got, input longint want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// driver: new beat at the falling edge once the previous one was taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
			gap_served <= 1'b0;
		end else if (!start || beat_taken) begin
			if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (op_queue.size() == 0) begin
				start <= 1'b0;
			end else if (!gap_served && op_queue[0].gap != 0) begin
				start <= 1'b0;
				idle_left <= op_queue[0].gap - 1;
				gap_served <= 1'b1;
			end else if (op_queue[0].drain && res_queue.size() != 0) begin
				start <= 1'b0;
			end else begin
				next_op = op_queue.pop_front();
				mode <= next_op.op;
				qa_w <= next_op.aw; qa_x <= next_op.ax; qa_y <= next_op.ay; qa_z <= next_op.az;
				qb_w <= next_op.bw; qb_x <= next_op.bx; qb_y <= next_op.by; qb_z <= next_op.bz;
				start <= 1'b1;
				gap_served <= 1'b0;
			end
		end
	end

	// monitor: check done beats first, then log the accepted start beat
	always @(posedge clk or negedge arst_n) begin
		quat_op_t  seen;
		quat_res_t want;
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= start && !busy;
			if (done) begin
				if (res_queue.size() == 0) begin
					report_mismatch("unexpected done beat", 1, 0);
				end else begin
					want = res_queue.pop_front();
					check_field("res_w", res_w, want.w);
					check_field("res_x", res_x, want.x);
					check_field("res_y", res_y, want.y);
					check_field("res_z", res_z, want.z);
					check_field("overflow", overflow, want.ovf);
					n_checked++;
					if (want.ovf)
						n_ovf++;
				end
			end
			if (start && !busy) begin
				seen = '{mode, qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z, 0, 1'b0};
				res_queue.push_back(hamilton_or_rotate(seen));
				mode_hits[mode]++;
			end
		end
	end

	task automatic add_op(input mode_t op, input data_t aw, ax, ay, az, bw, bx, by, bz,
			input int gap, input bit drain);
		op_queue.push_back('{op, aw, ax, ay, az, bw, bx, by, bz, gap, drain});
	endtask

	// near-unit magnitudes half the time, else extremes or full-range noise
	function automatic data_t rand_comp();
		case ($urandom_range(0, 9))
			0: return Q_MIN;
			1: return Q_MAX;
			2, 3, 4: return data_t'($urandom);
			default: return data_t'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
		endcase
	endfunction

	initial begin
		mode_t op;
		int    gap;
		bit    burst;
		int    spare_hits;
		foreach (mode_hits[k])
			mode_hits[k] = 0;

		add_op(MODE_MUL, '0, '0, '0, '0, '0, '0, '0, '0, 3, 1'b0);
		add_op(MODE_MUL, Q_ONE, '0, '0, '0, 8192, 4096, -4096, Q_ONE, 0, 1'b0);
		add_op(MODE_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1'b0);
		add_op(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1'b0);
		add_op(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 1'b0);
		add_op(MODE_CONJ_A, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 1'b0);
		add_op(MODE_CONJ_A, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1'b0);
		add_op(MODE_CONJ_B, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1'b1);
		add_op(MODE_CONJ_B, Q_ONE, -Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, 0, 2, 1'b0);
		add_op(MODE_ROT, Q_ONE, '0, '0, '0, Q_MIN, 5000, -7000, 9000, 0, 1'b0);
		add_op(MODE_ROT, Q_COS45, '0, '0, Q_COS45, '0, Q_ONE, '0, '0, 0, 1'b0);
		add_op(MODE_INV_ROT, Q_COS45, '0, '0, Q_COS45, Q_MAX, Q_ONE, '0, '0, 0, 1'b0);
		add_op(MODE_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0, Q_MAX, Q_MAX, Q_MAX, 0, 1'b0);
		add_op(MODE_INV_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1'b0);
		add_op(MODE_ROT, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 5, 1'b0);
		add_op(MODE_INV_ROT, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 1'b0);
		add_op(MODE_SPARE_FIRST, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1'b0);
		add_op(MODE_SPARE_LAST, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1'b0);
		add_op(MODE_MUL, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 0, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			burst = ((i / 64) % 3) == 0;
			gap = burst ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_GAP));
			if ($urandom_range(0, 19) < 18)
				op = mode_t'($urandom_range(MODE_MUL, MODE_INV_ROT));
			else
				op = mode_t'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
			add_op(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
				rand_comp(), rand_comp(), rand_comp(), rand_comp(), gap, (i % 300) == 150);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || start)
			@(posedge clk);
		while (res_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		spare_hits = 0;
		for (int k = MODE_SPARE_FIRST; k <= MODE_SPARE_LAST; k++)
			spare_hits += mode_hits[k];

		$display("checked %0d results (%0d saturated), %0d mismatches", n_checked, n_ovf,
			n_errors);
		$display("beats per mode: mul %0d, conj a %0d, conj b %0d, rot %0d, inv rot %0d, spare %0d",
			mode_hits[MODE_MUL], mode_hits[MODE_CONJ_A], mode_hits[MODE_CONJ_B],
			mode_hits[MODE_ROT], mode_hits[MODE_INV_ROT], spare_hits);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#200000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/qmru_pkg.sv
hdl/quaternion_multiply_rotate_unit.sv
bench/tb.sv
